>>> sv/assert_macros.svh
// Assertion helpers for the RTL; included by lift_motion_sequencer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check cons in the same cycle as ante.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check cons in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/lms_pkg.sv
`default_nettype none

package lms_pkg;

    localparam int LMS_DRUM_DIAMETER_MM = 30;
    localparam int LMS_DIST_NUM         = 1256;
    localparam int LMS_DELTA_W          = 33;
    localparam int LMS_DIVIDEND_W       =
        LMS_DELTA_W + $clog2(LMS_DRUM_DIAMETER_MM * LMS_DIST_NUM + 1);
    localparam int LMS_DIVISOR_W        = 23;
    localparam int LMS_QUOT_W           = 32;
    localparam int LMS_DIV_STEPS        = LMS_QUOT_W / 2;
    localparam int LMS_CFG_IDX_W        = 3;
    localparam int LMS_CFG_DATA_W       = 32;

    localparam logic [LMS_DIVISOR_W-1:0] LMS_PPT_SCALE     = 23'd100;
    localparam logic [LMS_DIVISOR_W-1:0] LMS_PPT_RESET_DIV = 23'd51200;
    localparam logic [LMS_DIVISOR_W-1:0] LMS_THR_DIVISOR   = 23'd5;

    localparam logic [LMS_CFG_IDX_W-1:0] CFG_TARGET_MM       = 3'd0;
    localparam logic [LMS_CFG_IDX_W-1:0] CFG_DESCENT_PROFILE = 3'd1;
    localparam logic [LMS_CFG_IDX_W-1:0] CFG_START_IN_RUN    = 3'd2;
    localparam logic [LMS_CFG_IDX_W-1:0] CFG_ENCODER_REF     = 3'd3;
    localparam logic [LMS_CFG_IDX_W-1:0] CFG_PULSES_PER_TURN = 3'd4;

    localparam logic [31:0] LMS_HOLD_MS      = 32'd5000;
    localparam logic [31:0] LMS_PULSE_OFF_MS = 32'd10000;
    localparam logic [31:0] LMS_PULSE_END_MS = 32'd10100;

    localparam logic signed [11:0] LMS_BRAKE_HOLD = -12'sd2000;
    localparam logic signed [11:0] LMS_BRAKE_FREE = 12'sd2000;

    localparam logic signed [14:0] LMS_DUTY_UP_FULL   = -15'sd10000;
    localparam logic signed [14:0] LMS_DUTY_UP_SLOW   = -15'sd5000;
    localparam logic signed [14:0] LMS_DUTY_DOWN_FULL = 15'sd10000;
    localparam logic signed [14:0] LMS_DUTY_DOWN_SLOW = 15'sd5000;

    typedef enum logic [3:0] {
        MODE_BOTTOM_STOP   = 4'd0,
        MODE_TOP_REACHED   = 4'd1,
        MODE_TOP_HOLD      = 4'd2,
        MODE_RUN_START     = 4'd3,
        MODE_START_HOLD    = 4'd4,
        MODE_CLIMB_FREE    = 4'd5,
        MODE_CLIMB_LOW     = 4'd6,
        MODE_CLIMB_MID     = 4'd7,
        MODE_CLIMB_HIGH    = 4'd8,
        MODE_VERT_START    = 4'd9,
        MODE_VERT_PULSE    = 4'd10,
        MODE_INCLINE_START = 4'd11,
        MODE_INCLINE_FAST  = 4'd12,
        MODE_INCLINE_SLOW  = 4'd13,
        MODE_DEBUG         = 4'd14
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_POST,
        S_STEP
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } t_div_sts;

endpackage

`default_nettype wire

>>> sv/lms_divider.sv
`default_nettype none

module lms_divider #(
    parameter int DIVIDEND_W = lms_pkg::LMS_DIVIDEND_W,
    parameter int DIVISOR_W  = lms_pkg::LMS_DIVISOR_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lms_pkg::t_div_ctl               i_ctl,
    input  logic [DIVIDEND_W-1:0]           i_dividend,
    input  logic [DIVISOR_W-1:0]            i_divisor,
    output logic [lms_pkg::LMS_QUOT_W-1:0]  o_quot,
    output lms_pkg::t_div_sts               o_sts
);
    import lms_pkg::*;

    localparam int REM_W = DIVISOR_W + 1;
    localparam int CNT_W = $clog2(LMS_DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LMS_DIV_STEPS - 1);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_ovf;
    logic [REM_W-1:0]      r_rem;
    logic [LMS_QUOT_W-1:0] r_low;
    logic [LMS_QUOT_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVIDEND_W-1:0] w_high;
    logic [REM_W-1:0]      w_dvs_ext;
    logic [REM_W-1:0]      w_t1;
    logic [REM_W-1:0]      w_r1;
    logic [REM_W-1:0]      w_t2;
    logic [REM_W-1:0]      w_r2;
    logic                  w_ge1;
    logic                  w_ge2;

    assign w_high    = i_dividend >> LMS_QUOT_W;
    assign w_dvs_ext = {1'b0, r_dvs};

    always_comb begin
        w_t1  = {r_rem[REM_W-2:0], r_low[LMS_QUOT_W-1]};
        w_ge1 = (w_t1 >= w_dvs_ext);
        w_r1  = w_ge1 ? (w_t1 - w_dvs_ext) : w_t1;
        w_t2  = {w_r1[REM_W-2:0], r_low[LMS_QUOT_W-2]};
        w_ge2 = (w_t2 >= w_dvs_ext);
        w_r2  = w_ge2 ? (w_t2 - w_dvs_ext) : w_t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_ovf  <= (w_high >= DIVIDEND_W'(i_divisor));
            r_rem  <= REM_W'(w_high);
            r_low  <= i_dividend[LMS_QUOT_W-1:0];
            r_dvs  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_r2;
            r_low  <= {r_low[LMS_QUOT_W-3:0], 2'b00};
            r_quot <= {r_quot[LMS_QUOT_W-3:0], w_ge1, w_ge2};
        end
    end

    assign o_quot     = r_quot;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && (r_cnt == CNT_LAST);
    assign o_sts.ovf  = r_ovf;

endmodule

`default_nettype wire

>>> sv/lift_motion_sequencer.sv
// Each input beat passes S_MUL, S_DIV, S_POST and S_STEP before its result beat;
// in modes 4, 6 and 11 a second divide forms the next distance threshold.
// Ticks are taken only in S_IDLE; both divides share the two-bit-per-cycle divider.
// Reset: synchronous, active low; mode 14 (debug), pulses per turn 512, state idle,
// other control registers zero; datapath and output data registers are not reset.
`default_nettype none

module lift_motion_sequencer #(
    parameter int DRUM_DIAMETER_MM = lms_pkg::LMS_DRUM_DIAMETER_MM
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [31:0]                 i_encoder_count,
    input  logic [31:0]                        i_now_ms,
    input  logic                               i_top_limit_rise,
    input  logic                               i_bottom_limit_rise,

    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_send_commands,
    output logic signed [11:0]                 o_brake_current_ma,
    output logic signed [14:0]                 o_drive_duty,
    output logic [3:0]                         o_mode_code,
    output logic signed [31:0]                 o_distance_q4,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lms_pkg::LMS_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lms_pkg::LMS_CFG_DATA_W-1:0] i_cfg_data
);
    import lms_pkg::*;

`include "assert_macros.svh"

    localparam int K_W   = $clog2(DRUM_DIAMETER_MM * LMS_DIST_NUM + 1);
    localparam int DVD_W = LMS_DELTA_W + K_W;
    localparam logic [K_W-1:0] DIST_K = K_W'(DRUM_DIAMETER_MM * LMS_DIST_NUM);

    t_state                   r_state, n_state;
    t_mode                    r_mode, n_mode;
    logic [31:0]              r_phase_ms, n_phase_ms;
    logic signed [31:0]       r_climb_thr, n_climb_thr;

    logic signed [20:0]       r_target, n_target;
    logic                     r_descent, n_descent;
    logic signed [31:0]       r_enc_ref, n_enc_ref;
    logic [LMS_DIVISOR_W-1:0] r_ppt_div, n_ppt_div;

    logic [31:0]              r_now, n_now;
    logic                     r_neg, n_neg;
    logic [LMS_DELTA_W-1:0]   r_mag, n_mag;
    logic                     r_pass, n_pass;
    logic signed [31:0]       r_dist, n_dist;
    logic signed [31:0]       r_thr_new, n_thr_new;
    logic [DVD_W-1:0]         r_dvd, n_dvd;
    logic [LMS_DIVISOR_W-1:0] r_dvs, n_dvs;
    logic                     r_div_start, n_div_start;

    logic                     r_out_valid, n_out_valid;
    logic                     r_o_send, n_o_send;
    logic signed [11:0]       r_o_brake, n_o_brake;
    logic signed [14:0]       r_o_duty, n_o_duty;
    logic [3:0]               r_o_mode, n_o_mode;
    logic signed [31:0]       r_o_dist, n_o_dist;

    logic [LMS_DELTA_W-1:0]   w_delta;
    logic [DVD_W-1:0]         w_prod;
    logic [15:0]              w_ppt_eff;
    logic [LMS_DIVISOR_W-1:0] w_ppt_div;
    logic [LMS_QUOT_W-1:0]    w_quot;
    t_div_ctl                 w_div_ctl;
    t_div_sts                 w_div_sts;
    logic [31:0]              w_dist_sat;
    logic [20:0]              w_tgt_mag;
    logic [DVD_W-1:0]         w_thr_dvd;
    logic                     w_thr_needed;
    logic [31:0]              w_thr_signed;
    logic signed [31:0]       w_tgt16;

    logic [31:0]              w_elapsed;
    t_mode                    w_step_mode;
    logic [31:0]              w_step_phase;
    logic signed [31:0]       w_step_thr;
    logic                     w_send;
    logic signed [11:0]       w_brake;
    logic signed [14:0]       w_duty;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    assign w_delta   = {i_encoder_count[31], i_encoder_count} - {r_enc_ref[31], r_enc_ref};
    assign w_prod    = {{K_W{1'b0}}, r_mag} * {{LMS_DELTA_W{1'b0}}, DIST_K};
    assign w_ppt_eff = (i_cfg_data[15:0] == 16'd0) ? 16'd1 : i_cfg_data[15:0];
    assign w_ppt_div = LMS_DIVISOR_W'(w_ppt_eff) * LMS_PPT_SCALE;
    assign w_tgt16   = {{7{r_target[20]}}, r_target, 4'b0000};
    assign w_tgt_mag = r_target[20] ? (~r_target + 21'd1) : r_target;

    assign w_div_ctl.start = r_div_start;

    lms_divider #(
        .DIVIDEND_W (DVD_W),
        .DIVISOR_W  (LMS_DIVISOR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_quot     (w_quot),
        .o_sts      (w_div_sts)
    );

    always_comb begin
        if (r_neg) begin
            w_dist_sat = (w_div_sts.ovf || (w_quot > 32'h8000_0000)) ?
                         32'h8000_0000 : (~w_quot + 32'd1);
        end else begin
            w_dist_sat = (w_div_sts.ovf || w_quot[31]) ? 32'h7FFF_FFFF : w_quot;
        end
        w_thr_signed = r_target[20] ? (~w_quot + 32'd1) : w_quot;
    end

    always_comb begin
        w_thr_needed = 1'b1;
        case (r_mode)
            MODE_START_HOLD:    w_thr_dvd = DVD_W'({w_tgt_mag, 4'b0000});
            MODE_CLIMB_LOW:     w_thr_dvd = DVD_W'({w_tgt_mag, 6'b000000});
            MODE_INCLINE_START: w_thr_dvd = DVD_W'({w_tgt_mag, 3'b000});
            default: begin
                w_thr_dvd    = '0;
                w_thr_needed = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_elapsed    = r_now - r_phase_ms;
        w_step_mode  = r_mode;
        w_step_phase = r_phase_ms;
        w_step_thr   = r_climb_thr;
        w_send       = 1'b1;
        w_brake      = '0;
        w_duty       = '0;
        case (r_mode)
            MODE_BOTTOM_STOP: begin
                w_brake = LMS_BRAKE_HOLD;
            end
            MODE_TOP_REACHED: begin
                w_send       = 1'b0;
                w_step_phase = r_now;
                w_step_mode  = MODE_TOP_HOLD;
            end
            MODE_TOP_HOLD: begin
                w_brake = LMS_BRAKE_HOLD;
                if (w_elapsed > LMS_HOLD_MS) begin
                    w_step_mode = r_descent ? MODE_INCLINE_START : MODE_VERT_START;
                end
            end
            MODE_RUN_START: begin
                w_send       = 1'b0;
                w_step_phase = r_now;
                w_step_mode  = MODE_START_HOLD;
            end
            MODE_START_HOLD: begin
                w_brake = LMS_BRAKE_HOLD;
                if (w_elapsed > LMS_HOLD_MS) begin
                    w_step_mode = MODE_CLIMB_LOW;
                    w_step_thr  = r_thr_new;
                end
            end
            MODE_CLIMB_FREE: begin
                w_brake = LMS_BRAKE_FREE;
                w_duty  = LMS_DUTY_UP_FULL;
            end
            MODE_CLIMB_LOW: begin
                w_brake = LMS_BRAKE_FREE;
                w_duty  = LMS_DUTY_UP_SLOW;
                if (r_dist > r_climb_thr) begin
                    w_step_mode = MODE_CLIMB_MID;
                    w_step_thr  = r_thr_new;
                end
            end
            MODE_CLIMB_MID: begin
                w_brake = LMS_BRAKE_FREE;
                w_duty  = LMS_DUTY_UP_FULL;
                if (r_dist > r_climb_thr) begin
                    w_step_mode = MODE_CLIMB_HIGH;
                end
            end
            MODE_CLIMB_HIGH: begin
                w_brake = LMS_BRAKE_FREE;
                w_duty  = LMS_DUTY_UP_SLOW;
                if (r_dist > w_tgt16) begin
                    w_step_mode = MODE_TOP_REACHED;
                end
            end
            MODE_VERT_START: begin
                w_send       = 1'b0;
                w_step_phase = r_now;
                w_step_mode  = MODE_VERT_PULSE;
            end
            MODE_VERT_PULSE: begin
                w_brake = LMS_BRAKE_HOLD;
                if (w_elapsed > LMS_PULSE_OFF_MS) begin
                    w_brake = LMS_BRAKE_FREE;
                    if (w_elapsed > LMS_PULSE_END_MS) begin
                        w_step_phase = r_now;
                    end
                end
            end
            MODE_INCLINE_START: begin
                w_send       = 1'b0;
                w_step_phase = r_now;
                w_step_mode  = MODE_INCLINE_FAST;
                w_step_thr   = r_thr_new;
            end
            MODE_INCLINE_FAST: begin
                w_brake = LMS_BRAKE_FREE;
                w_duty  = LMS_DUTY_DOWN_FULL;
                if (r_dist < r_climb_thr) begin
                    w_step_mode = MODE_INCLINE_SLOW;
                end
            end
            MODE_INCLINE_SLOW: begin
                w_brake = LMS_BRAKE_FREE;
                w_duty  = LMS_DUTY_DOWN_SLOW;
                if (r_dist < 32'sd0) begin
                    w_step_mode = MODE_BOTTOM_STOP;
                end
            end
            default: begin
                w_step_mode = MODE_DEBUG;
                w_brake     = LMS_BRAKE_FREE;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_phase_ms  = r_phase_ms;
        n_climb_thr = r_climb_thr;
        n_target    = r_target;
        n_descent   = r_descent;
        n_enc_ref   = r_enc_ref;
        n_ppt_div   = r_ppt_div;
        n_now       = r_now;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_pass      = r_pass;
        n_dist      = r_dist;
        n_thr_new   = r_thr_new;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_div_start = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_send    = r_o_send;
        n_o_brake   = r_o_brake;
        n_o_duty    = r_o_duty;
        n_o_mode    = r_o_mode;
        n_o_dist    = r_o_dist;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    case (i_cfg_index)
                        CFG_TARGET_MM:       n_target  = i_cfg_data[20:0];
                        CFG_DESCENT_PROFILE: n_descent = i_cfg_data[0];
                        CFG_START_IN_RUN:    n_mode    = i_cfg_data[0] ? MODE_RUN_START
                                                                       : MODE_DEBUG;
                        CFG_ENCODER_REF:     n_enc_ref = i_cfg_data;
                        CFG_PULSES_PER_TURN: n_ppt_div = w_ppt_div;
                        default: ;
                    endcase
                end
                if (i_in_valid) begin
                    n_now  = i_now_ms;
                    n_neg  = w_delta[LMS_DELTA_W-1];
                    n_mag  = w_delta[LMS_DELTA_W-1] ? (~w_delta + 1'b1) : w_delta;
                    n_pass = 1'b0;
                    if (i_bottom_limit_rise) begin
                        n_mode     = MODE_BOTTOM_STOP;
                        n_phase_ms = i_now_ms;
                    end else if (i_top_limit_rise) begin
                        n_mode     = MODE_TOP_REACHED;
                        n_phase_ms = i_now_ms;
                    end
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_dvd       = w_prod;
                n_dvs       = r_ppt_div;
                n_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (!r_pass) begin
                    n_dist = w_dist_sat;
                    if (w_thr_needed) begin
                        n_dvd       = w_thr_dvd;
                        n_dvs       = LMS_THR_DIVISOR;
                        n_div_start = 1'b1;
                        n_pass      = 1'b1;
                        n_state     = S_DIV;
                    end else begin
                        n_state = S_STEP;
                    end
                end else begin
                    n_thr_new = w_thr_signed;
                    n_state   = S_STEP;
                end
            end
            S_STEP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_mode      = w_step_mode;
                    n_phase_ms  = w_step_phase;
                    n_climb_thr = w_step_thr;
                    n_out_valid = 1'b1;
                    n_o_send    = w_send;
                    n_o_brake   = w_brake;
                    n_o_duty    = w_duty;
                    n_o_mode    = w_step_mode;
                    n_o_dist    = r_dist;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_DEBUG;
            r_phase_ms  <= '0;
            r_climb_thr <= '0;
            r_target    <= '0;
            r_descent   <= 1'b0;
            r_enc_ref   <= '0;
            r_ppt_div   <= LMS_PPT_RESET_DIV;
            r_pass      <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_phase_ms  <= n_phase_ms;
            r_climb_thr <= n_climb_thr;
            r_target    <= n_target;
            r_descent   <= n_descent;
            r_enc_ref   <= n_enc_ref;
            r_ppt_div   <= n_ppt_div;
            r_pass      <= n_pass;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_neg     <= n_neg;
        r_mag     <= n_mag;
        r_dist    <= n_dist;
        r_thr_new <= n_thr_new;
        r_dvd     <= n_dvd;
        r_dvs     <= n_dvs;
        r_o_send  <= n_o_send;
        r_o_brake <= n_o_brake;
        r_o_duty  <= n_o_duty;
        r_o_mode  <= n_o_mode;
        r_o_dist  <= n_o_dist;
    end

    assign o_out_valid        = r_out_valid;
    assign o_send_commands    = r_o_send;
    assign o_brake_current_ma = r_o_brake;
    assign o_drive_duty       = r_o_duty;
    assign o_mode_code        = r_o_mode;
    assign o_distance_q4      = r_o_dist;

    `ASSERT_NEXT(a_accept_to_mul, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_MUL)
    `ASSERT_IMPLY(a_done_in_div, i_clk, i_rst_n, w_div_sts.done, r_state == S_DIV)
    `ASSERT_IMPLY(a_div_free_at_mul, i_clk, i_rst_n, r_state == S_MUL, !w_div_sts.busy)
    `ASSERT_IMPLY(a_thr_pass_mode, i_clk, i_rst_n, r_state == S_STEP && r_pass, r_mode == MODE_START_HOLD || r_mode == MODE_CLIMB_LOW || r_mode == MODE_INCLINE_START)
    `ASSERT_NEXT(a_step_loads_out, i_clk, i_rst_n, r_state == S_STEP && (!r_out_valid || !i_out_stall), r_out_valid && r_state == S_IDLE)

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lms_pkg::*;

    localparam longint DRUM_MM     = 30;
    localparam longint ARC_NUM     = 1256;
    localparam longint ARC_DEN     = 100;
    localparam longint Q4_MAX      = 64'sd2147483647;
    localparam longint Q4_MIN      = -64'sd2147483648;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     ITEM_GOAL   = 1950;
    localparam int     LOG_LIMIT   = 100;

    typedef struct {
        logic signed [31:0] count;
        logic [31:0]        now_ms;
        logic               top_rise;
        logic               bottom_rise;
    } tick_t;

    typedef struct {
        logic               send;
        logic signed [11:0] brake_ma;
        logic signed [14:0] duty;
        logic [3:0]         mode;
        logic signed [31:0] dist_q4;
    } command_t;

    class lift_scoreboard;
        logic signed [20:0] target_mm;
        logic               incline;
        logic signed [31:0] enc_zero;
        logic [15:0]        ppt;
        t_mode              mode;
        logic [31:0]        phase_ms;
        longint             threshold_q4;
        command_t           expected_cmds[$];
        int                 errors;

        function new();
            target_mm    = '0;
            incline      = 1'b0;
            enc_zero     = '0;
            ppt          = 16'd512;
            mode         = MODE_DEBUG;
            phase_ms     = '0;
            threshold_q4 = 0;
            errors       = 0;
        endfunction

        function void write_reg(logic [LMS_CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_TARGET_MM:       target_mm = data[20:0];
                CFG_DESCENT_PROFILE: incline = data[0];
                CFG_START_IN_RUN: begin
                    if (data[0])
                        mode = MODE_RUN_START;
                    else
                        mode = MODE_DEBUG;
                end
                CFG_ENCODER_REF:     enc_zero = data;
                CFG_PULSES_PER_TURN: ppt = data[15:0];
                default: ;
            endcase
        endfunction

        function longint travel_q4(logic signed [31:0] count);
            longint delta;
            longint div;
            longint q;
            delta = longint'(count) - longint'(enc_zero);
            div   = (ppt == 16'd0) ? 1 : longint'(ppt);
            q     = (delta * DRUM_MM * ARC_NUM) / (ARC_DEN * div);
            if (q > Q4_MAX)
                q = Q4_MAX;
            if (q < Q4_MIN)
                q = Q4_MIN;
            return q;
        endfunction

        function void note(tick_t t);
            longint      travel;
            longint      tgt16;
            logic [31:0] elapsed;
            command_t    c;
            if (t.bottom_rise) begin
                mode     = MODE_BOTTOM_STOP;
                phase_ms = t.now_ms;
            end else if (t.top_rise) begin
                mode     = MODE_TOP_REACHED;
                phase_ms = t.now_ms;
            end
            travel     = travel_q4(t.count);
            tgt16      = longint'(target_mm) * 16;
            elapsed    = t.now_ms - phase_ms;
            c.send     = 1'b1;
            c.brake_ma = '0;
            c.duty     = '0;
            case (mode)
                MODE_BOTTOM_STOP: c.brake_ma = LMS_BRAKE_HOLD;
                MODE_TOP_REACHED: begin
                    c.send   = 1'b0;
                    phase_ms = t.now_ms;
                    mode     = MODE_TOP_HOLD;
                end
                MODE_TOP_HOLD: begin
                    c.brake_ma = LMS_BRAKE_HOLD;
                    if (elapsed > LMS_HOLD_MS) begin
                        if (incline)
                            mode = MODE_INCLINE_START;
                        else
                            mode = MODE_VERT_START;
                    end
                end
                MODE_RUN_START: begin
                    c.send   = 1'b0;
                    phase_ms = t.now_ms;
                    mode     = MODE_START_HOLD;
                end
                MODE_START_HOLD: begin
                    c.brake_ma = LMS_BRAKE_HOLD;
                    if (elapsed > LMS_HOLD_MS) begin
                        mode         = MODE_CLIMB_LOW;
                        threshold_q4 = (tgt16 * 2) / 10;
                    end
                end
                MODE_CLIMB_FREE: begin
                    c.brake_ma = LMS_BRAKE_FREE;
                    c.duty     = LMS_DUTY_UP_FULL;
                end
                MODE_CLIMB_LOW: begin
                    c.brake_ma = LMS_BRAKE_FREE;
                    c.duty     = LMS_DUTY_UP_SLOW;
                    if (travel > threshold_q4) begin
                        mode         = MODE_CLIMB_MID;
                        threshold_q4 = (tgt16 * 8) / 10;
                    end
                end
                MODE_CLIMB_MID: begin
                    c.brake_ma = LMS_BRAKE_FREE;
                    c.duty     = LMS_DUTY_UP_FULL;
                    if (travel > threshold_q4)
                        mode = MODE_CLIMB_HIGH;
                end
                MODE_CLIMB_HIGH: begin
                    c.brake_ma = LMS_BRAKE_FREE;
                    c.duty     = LMS_DUTY_UP_SLOW;
                    if (travel > tgt16)
                        mode = MODE_TOP_REACHED;
                end
                MODE_VERT_START: begin
                    c.send   = 1'b0;
                    phase_ms = t.now_ms;
                    mode     = MODE_VERT_PULSE;
                end
                MODE_VERT_PULSE: begin
                    c.brake_ma = LMS_BRAKE_HOLD;
                    if (elapsed > LMS_PULSE_OFF_MS) begin
                        c.brake_ma = LMS_BRAKE_FREE;
                        if (elapsed > LMS_PULSE_END_MS)
                            phase_ms = t.now_ms;
                    end
                end
                MODE_INCLINE_START: begin
                    c.send       = 1'b0;
                    phase_ms     = t.now_ms;
                    mode         = MODE_INCLINE_FAST;
                    threshold_q4 = tgt16 / 10;
                end
                MODE_INCLINE_FAST: begin
                    c.brake_ma = LMS_BRAKE_FREE;
                    c.duty     = LMS_DUTY_DOWN_FULL;
                    if (travel < threshold_q4)
                        mode = MODE_INCLINE_SLOW;
                end
                MODE_INCLINE_SLOW: begin
                    c.brake_ma = LMS_BRAKE_FREE;
                    c.duty     = LMS_DUTY_DOWN_SLOW;
                    if (travel < 0)
                        mode = MODE_BOTTOM_STOP;
                end
                default: begin
                    mode       = MODE_DEBUG;
                    c.brake_ma = LMS_BRAKE_FREE;
                end
            endcase
            c.mode    = mode;
            c.dist_q4 = travel[31:0];
            expected_cmds.push_back(c);
        endfunction

        task report(string msg);
            if (errors < LOG_LIMIT)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(command_t got);
            command_t want;
            if (expected_cmds.size() == 0) begin
                report($sformatf("result beat with nothing outstanding, mode %0d", got.mode));
                return;
            end
            want = expected_cmds.pop_front();
            if (got.send !== want.send)
                report($sformatf("send_commands %b, want %b", got.send, want.send));
            if (got.brake_ma !== want.brake_ma)
                report($sformatf("brake_current_ma %0d, want %0d", got.brake_ma, want.brake_ma));
            if (got.duty !== want.duty)
                report($sformatf("drive_duty %0d, want %0d", got.duty, want.duty));
            if (got.mode !== want.mode)
                report($sformatf("mode_code %0d, want %0d", got.mode, want.mode));
            if (got.dist_q4 !== want.dist_q4)
                report($sformatf("distance_q4 %0d, want %0d", got.dist_q4, want.dist_q4));
        endtask
    endclass

    logic                       i_clk               = 1'b0;
    logic                       i_rst_n             = 1'b0;
    logic                       i_in_valid          = 1'b0;
    logic                       o_in_stall;
    logic signed [31:0]         i_encoder_count     = '0;
    logic [31:0]                i_now_ms            = '0;
    logic                       i_top_limit_rise    = 1'b0;
    logic                       i_bottom_limit_rise = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall         = 1'b0;
    logic                       o_send_commands;
    logic signed [11:0]         o_brake_current_ma;
    logic signed [14:0]         o_drive_duty;
    logic [3:0]                 o_mode_code;
    logic signed [31:0]         o_distance_q4;
    logic                       i_cfg_valid         = 1'b0;
    logic                       o_cfg_ready;
    logic [LMS_CFG_IDX_W-1:0]   i_cfg_index         = '0;
    logic [LMS_CFG_DATA_W-1:0]  i_cfg_data          = '0;

    lift_scoreboard             sb = new();
    command_t                   seen;
    int                         cycles = 0;
    int                         sent = 0;
    bit                         calm = 1'b0;
    logic [31:0]                clock_ms = '0;
    logic signed [31:0]         enc_pos = '0;
    longint                     stride = 1;
    logic [LMS_CFG_IDX_W-1:0]   pend_idx[$];
    logic [31:0]                pend_val[$];

    lift_motion_sequencer i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_encoder_count     (i_encoder_count),
        .i_now_ms            (i_now_ms),
        .i_top_limit_rise    (i_top_limit_rise),
        .i_bottom_limit_rise (i_bottom_limit_rise),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_send_commands     (o_send_commands),
        .o_brake_current_ma  (o_brake_current_ma),
        .o_drive_duty        (o_drive_duty),
        .o_mode_code         (o_mode_code),
        .o_distance_q4       (o_distance_q4),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 29);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.send     = o_send_commands;
            seen.brake_ma = o_brake_current_ma;
            seen.duty     = o_drive_duty;
            seen.mode     = o_mode_code;
            seen.dist_q4  = o_distance_q4;
            sb.check(seen);
        end
    end

    task automatic pause_in();
        if (calm)
            return;
        while ($urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        if ($urandom_range(39) == 0) begin
            repeat ($urandom_range(60, 20)) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic send_tick(input logic signed [31:0] count, input logic [31:0] now,
                             input logic top, input logic bottom);
        tick_t t;
        t.count       = count;
        t.now_ms      = now;
        t.top_rise    = top;
        t.bottom_rise = bottom;
        pause_in();
        i_in_valid          <= 1'b1;
        i_encoder_count     <= count;
        i_now_ms            <= now;
        i_top_limit_rise    <= top;
        i_bottom_limit_rise <= bottom;
        do @(posedge i_clk); while (o_in_stall);
        sb.note(t);
        sent++;
    endtask

    task automatic queue_reg(input logic [LMS_CFG_IDX_W-1:0] idx, input logic [31:0] data);
        pend_idx.push_back(idx);
        pend_val.push_back(data);
    endtask

    // drain the pipe, then write the queued registers back to back
    task automatic write_settings();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_cmds.size() != 0);
        foreach (pend_idx[k]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= pend_idx[k];
            i_cfg_data  <= pend_val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(pend_idx[k], pend_val[k]);
        end
        i_cfg_valid <= 1'b0;
        pend_idx.delete();
        pend_val.delete();
    endtask

    task automatic random_tick();
        int          roll;
        logic [31:0] elapsed;
        logic [31:0] aim;
        logic        top;
        logic        bottom;
        bit          aimed;
        roll = $urandom_range(99);
        if (roll < 8) begin
            send_tick($urandom, $urandom, $urandom_range(7) == 0, $urandom_range(7) == 0);
            return;
        end
        elapsed = clock_ms - sb.phase_ms;
        top     = 1'b0;
        bottom  = 1'b0;
        aimed   = 1'b0;
        case (sb.mode)
            MODE_START_HOLD, MODE_TOP_HOLD: begin
                aim = LMS_HOLD_MS + $urandom_range(1);
                if (roll < 30 && elapsed < aim) begin
                    clock_ms = sb.phase_ms + aim;
                    aimed    = 1'b1;
                end
            end
            MODE_VERT_PULSE: begin
                aim = ($urandom_range(1) ? LMS_PULSE_END_MS : LMS_PULSE_OFF_MS)
                      + $urandom_range(1);
                if (roll < 30 && elapsed < aim) begin
                    clock_ms = sb.phase_ms + aim;
                    aimed    = 1'b1;
                end
                bottom = ($urandom_range(29) == 0);
            end
            MODE_CLIMB_LOW, MODE_CLIMB_MID, MODE_CLIMB_HIGH: begin
                if (roll < 25)
                    enc_pos = enc_pos + $urandom_range(2);
                else
                    enc_pos = enc_pos + $urandom_range(int'(stride));
                top = (sb.mode == MODE_CLIMB_HIGH) && ($urandom_range(24) == 0);
            end
            MODE_INCLINE_FAST, MODE_INCLINE_SLOW: begin
                if (roll < 25)
                    enc_pos = enc_pos - $urandom_range(2);
                else
                    enc_pos = enc_pos - $urandom_range(int'(stride));
                bottom = (sb.mode == MODE_INCLINE_SLOW) && ($urandom_range(29) == 0);
            end
            MODE_BOTTOM_STOP, MODE_DEBUG: top = ($urandom_range(14) == 0);
            default: ;
        endcase
        if (!aimed)
            clock_ms = clock_ms + $urandom_range(400);
        if (sb.mode != MODE_CLIMB_LOW && sb.mode != MODE_CLIMB_MID &&
            sb.mode != MODE_CLIMB_HIGH && sb.mode != MODE_INCLINE_FAST &&
            sb.mode != MODE_INCLINE_SLOW)
            enc_pos = enc_pos + $urandom_range(2) - 1;
        if ($urandom_range(59) == 0) begin
            top    = 1'b1;
            bottom = 1'b1;
        end
        send_tick(enc_pos, clock_ms, top, bottom);
    endtask

    task automatic random_phase(input int n_ticks);
        longint      tgt;
        longint      span;
        longint      ppt_eff;
        logic [31:0] d;
        logic [31:0] zero_at;
        logic [15:0] ppt;
        bit          start_first;
        case ($urandom_range(9))
            0, 1, 2: tgt = $urandom_range(50);
            3, 4, 5: tgt = $urandom_range(5000, 50);
            6:       tgt = $urandom_range(200000, 5000);
            7:       tgt = -longint'($urandom_range(5000, 1));
            8:       tgt = $urandom_range(1) ? 1048575 : -1048576;
            default: tgt = longint'($signed(21'($urandom)));
        endcase
        case ($urandom_range(15))
            0:       ppt = 16'd0;
            1:       ppt = 16'hFFFF;
            2:       ppt = 16'd1;
            default: ppt = 16'($urandom_range(2048, 1));
        endcase
        zero_at     = $urandom;
        start_first = ($urandom_range(3) == 0);
        d           = $urandom;
        d[0]        = ($urandom_range(9) != 0);
        if (start_first)
            queue_reg(CFG_START_IN_RUN, d);
        d       = $urandom;
        d[20:0] = tgt[20:0];
        queue_reg(CFG_TARGET_MM, d);
        queue_reg(CFG_DESCENT_PROFILE, $urandom);
        queue_reg(CFG_ENCODER_REF, zero_at);
        d       = $urandom;
        d[15:0] = ppt;
        queue_reg(CFG_PULSES_PER_TURN, d);
        if ($urandom_range(5) == 0)
            queue_reg(LMS_CFG_IDX_W'(CFG_PULSES_PER_TURN + $urandom_range(3, 1)), $urandom);
        if (!start_first) begin
            d    = $urandom;
            d[0] = ($urandom_range(9) != 0);
            queue_reg(CFG_START_IN_RUN, d);
        end
        write_settings();

        enc_pos  = zero_at;
        clock_ms = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(8000) : $urandom;
        ppt_eff  = (ppt == 16'd0) ? 1 : longint'(ppt);
        span     = ((tgt < 0) ? -tgt : tgt) * 16 * ARC_DEN * ppt_eff / (DRUM_MM * ARC_NUM) + 1;
        stride   = span / 6 + 1;
        if (stride > (longint'(1) << 28))
            stride = longint'(1) << 28;
        repeat (n_ticks) random_tick();
    endtask

    initial begin
        int p;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // out of reset: debug mode, limit rises, both rises at once
        send_tick(32'sh7FFF_FFFF, 32'd0, 1'b0, 1'b0);
        send_tick(32'sh8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd10, 1'b1, 1'b0);
        send_tick(32'sd0, 32'd11, 1'b1, 1'b1);
        send_tick(-32'sd5, 32'd12, 1'b0, 1'b0);

        // zero pulses per turn, saturation both ways, an unused index
        queue_reg(CFG_ENCODER_REF, 32'h8000_0000);
        queue_reg(CFG_PULSES_PER_TURN, 32'hFFFF_0000);
        queue_reg(CFG_TARGET_MM, 32'hFFF0_0000);
        queue_reg(CFG_DESCENT_PROFILE, 32'hFFFF_FFFF);
        queue_reg(CFG_START_IN_RUN, 32'hFFFF_FFFE);
        queue_reg(CFG_PULSES_PER_TURN + 3'd3, 32'hFFFF_FFFF);
        write_settings();
        send_tick(32'sh7FFF_FFFF, 32'd13, 1'b0, 1'b0);
        queue_reg(CFG_ENCODER_REF, 32'h7FFF_FFFF);
        write_settings();
        send_tick(32'sh8000_0000, 32'd14, 1'b0, 1'b0);

        // full climb and incline descent on a short target
        queue_reg(CFG_TARGET_MM, 32'd10);
        queue_reg(CFG_ENCODER_REF, 32'd0);
        queue_reg(CFG_PULSES_PER_TURN, 32'd1);
        queue_reg(CFG_START_IN_RUN, 32'd1);
        write_settings();
        send_tick(32'sd0, 32'd1000, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd6000, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd6001, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd6100, 1'b0, 1'b0);
        send_tick(32'sd1, 32'd6200, 1'b0, 1'b0);
        send_tick(32'sd1, 32'd6300, 1'b0, 1'b0);
        send_tick(32'sd1, 32'd6400, 1'b0, 1'b0);
        send_tick(32'sd1, 32'd7000, 1'b0, 1'b0);
        send_tick(32'sd1, 32'd12001, 1'b0, 1'b0);
        send_tick(32'sd1, 32'd12002, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd12100, 1'b0, 1'b0);
        send_tick(-32'sd1, 32'd12200, 1'b0, 1'b0);

        // vertical descent across the pulse edges
        queue_reg(CFG_DESCENT_PROFILE, 32'd0);
        write_settings();
        send_tick(32'sd0, 32'd20000, 1'b1, 1'b0);
        send_tick(32'sd0, 32'd25001, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd25002, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd35002, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd35003, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd35102, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd35103, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd35104, 1'b0, 1'b0);
        send_tick(32'sd0, 32'd35200, 1'b0, 1'b1);

        p = 0;
        while (sent < ITEM_GOAL) begin
            calm = (p == 4);
            random_phase($urandom_range(260, 60));
            p++;
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_cmds.size() != 0);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> lift_motion_sequencer.f
+incdir+sv
sv/lms_pkg.sv
sv/lms_divider.sv
sv/lift_motion_sequencer.sv
tb/tb.sv
